### src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared definitions for the sorted list engine
// Operation codes, field widths and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int FUNC_W       = 2;
    localparam int ENTRY_W      = 5;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_REMOVE   = 2'd1,
        FUNC_CONTAINS = 2'd2
    } t_func;

    typedef struct packed {
        logic start;
        logic check;
        logic eval;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic finish;
    } t_sts;

endpackage

### src/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine: bounded sorted multiset of signed 32-bit values
// Insert, remove-one and membership test over an ascending entry store.
// ----------------------------------------------------------------------------
// Operations arrive on the s_axis channel: tuser carries the operation
// (insert, remove one match, test membership) and tdata the signed value.
// Each transfer yields exactly one result on the m_axis channel carrying an
// ok flag, the entry count after the operation and an empty flag.
// Entries live in a memory of CAPACITY words and are walked one word per
// check and evaluate step pair (read, then compare and shift). Insert scans
// down from the top, remove and the membership test scan up from the bottom
// and stop early once the stored value passes the key before any match. One
// operation is in progress at a time; the input is ready again as soon as
// the result is in the output register.
// Reset empties the list at once. When the receiver stalls, the result waits
// in the output register; the next operation may be taken and worked on, but
// it holds its result until the register has been emptied.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sle_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [31:0] value
    input  logic [sle_pkg::FUNC_W-1:0]      s_axis_tuser,  // [1:0] func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sle_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // [0] ok, [5:1] entry_count,
                                                           // [6] empty_res, [7] zero
);

    sle_pkg::t_cmd w_cmd;
    sle_pkg::t_sts w_sts;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_func   (s_axis_tuser),
        .i_value  (s_axis_tdata),
        .o_result (m_axis_tdata)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an operation is in progress");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over one not yet taken");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");

    a_phase_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.check && w_cmd.eval) && !(w_cmd.start && (w_cmd.check || w_cmd.eval)))
        else $error("controller phases overlap");

endmodule

### src/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl: sequencing controller for the sorted list engine
// Steps each operation through check and evaluate phases and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module sle_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  sle_pkg::t_sts i_sts,
    output sle_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.finish ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                n_state = i_sts.finish ? S_DONE : S_CHECK;
            end
            S_DONE: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### src/sle_datapath.sv
// ----------------------------------------------------------------------------
// sle_datapath: entry store, scan index and result register
// Walks the sorted entry memory one word per evaluate step, shifting entries
// to open or close a gap, and keeps the entry count.
// ----------------------------------------------------------------------------
module sle_datapath #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sle_pkg::t_cmd                   i_cmd,
    output sle_pkg::t_sts                   o_sts,
    input  logic [sle_pkg::FUNC_W-1:0]      i_func,
    input  logic [sle_pkg::VALUE_W-1:0]     i_value,
    output logic [sle_pkg::OUT_DATA_W-1:0]  o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [sle_pkg::FUNC_W-1:0]     r_func, n_func;
    logic signed [sle_pkg::VALUE_W-1:0] r_key, n_key;
    logic [CW-1:0]                  r_idx, n_idx;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_found, n_found;
    logic                           r_res_ok, n_res_ok;
    logic [sle_pkg::OUT_DATA_W-1:0] r_result, n_result;

    logic                               w_wr_en;
    logic [AW-1:0]                      w_wr_addr;
    logic signed [sle_pkg::VALUE_W-1:0] w_wr_data;
    logic [AW-1:0]                      w_rd_addr;
    logic signed [sle_pkg::VALUE_W-1:0] w_rd_data;
    logic [CW-1:0]                      w_idx_dec;
    logic                               w_eq;
    logic                               w_gt;
    logic                               w_finish;

    sle_ram #(
        .WIDTH (sle_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_idx_dec = r_idx - 1'b1;
    assign w_rd_addr = (r_func == sle_pkg::FUNC_INSERT) ? w_idx_dec[AW-1:0] : r_idx[AW-1:0];
    assign w_eq      = (w_rd_data == r_key);
    assign w_gt      = (w_rd_data > r_key);

    always_comb begin
        n_func    = r_func;
        n_key     = r_key;
        n_idx     = r_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_res_ok  = r_res_ok;
        n_result  = r_result;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[AW-1:0];
        w_wr_data = r_key;
        w_finish  = 1'b0;

        if (i_cmd.start) begin
            n_func  = i_func;
            n_key   = i_value;
            n_found = 1'b0;
            n_idx   = (i_func == sle_pkg::FUNC_INSERT) ? r_count : '0;
        end

        if (i_cmd.check) begin
            case (r_func)
                sle_pkg::FUNC_INSERT: begin
                    if (r_count == CW'(CAPACITY)) begin
                        w_finish = 1'b1;
                        n_res_ok = 1'b0;
                    end else if (r_idx == '0) begin
                        w_wr_en  = 1'b1;
                        w_finish = 1'b1;
                        n_res_ok = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end
                sle_pkg::FUNC_REMOVE: begin
                    if (r_idx == r_count) begin
                        w_finish = 1'b1;
                        n_res_ok = r_found;
                        if (r_found) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                sle_pkg::FUNC_CONTAINS: begin
                    if (r_idx == r_count) begin
                        w_finish = 1'b1;
                        n_res_ok = 1'b0;
                    end
                end
                default: begin
                    w_finish = 1'b1;
                    n_res_ok = 1'b0;
                end
            endcase
        end

        if (i_cmd.eval) begin
            case (r_func)
                sle_pkg::FUNC_INSERT: begin
                    w_wr_en = 1'b1;
                    if (w_gt) begin
                        w_wr_data = w_rd_data;
                        n_idx     = w_idx_dec;
                    end else begin
                        w_finish = 1'b1;
                        n_res_ok = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end
                sle_pkg::FUNC_REMOVE: begin
                    if (r_found) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_idx_dec[AW-1:0];
                        w_wr_data = w_rd_data;
                        n_idx     = r_idx + 1'b1;
                    end else if (w_eq) begin
                        n_found = 1'b1;
                        n_idx   = r_idx + 1'b1;
                    end else if (w_gt) begin
                        w_finish = 1'b1;
                        n_res_ok = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                sle_pkg::FUNC_CONTAINS: begin
                    if (w_eq) begin
                        w_finish = 1'b1;
                        n_res_ok = 1'b1;
                    end else if (w_gt) begin
                        w_finish = 1'b1;
                        n_res_ok = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                default: begin
                    w_finish = 1'b1;
                    n_res_ok = 1'b0;
                end
            endcase
        end

        if (i_cmd.load_out) begin
            n_result = {1'b0, (r_count == '0), sle_pkg::ENTRY_W'(r_count), r_res_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_func   <= n_func;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_res_ok <= n_res_ok;
        r_result <= n_result;
    end

    assign o_sts.finish = w_finish;
    assign o_result     = r_result;

endmodule
